@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared property wrappers for clocked checks with an active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/bdq_pkg.sv @@
// ---------------------------------------------------------------------------
// bdq_pkg
// shared types and constants of the bounded deque with search
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_BACK,
    OP_READ,
    OP_FIND,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } entry_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [POS_W-1:0]          result_position;
    logic [STATUS_W-1:0]       status;
  } result_t;

endpackage

@@ design/bdq_cmd_if.sv @@
// ---------------------------------------------------------------------------
// bdq_cmd_if
// command channel: valid/ready handshake with one command item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bdq_cmd_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] data_value;
  logic [POS_W-1:0]          position;

  modport source (output valid, cmd, data_value, position, input ready);
  modport sink   (input valid, cmd, data_value, position, output ready);
endinterface

@@ design/bdq_res_if.sv @@
// ---------------------------------------------------------------------------
// bdq_res_if
// result channel: valid/ready handshake with one result item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bdq_res_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [POS_W-1:0]          result_position;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, result_value, result_position, status, input ready);
  modport sink   (input valid, result_value, result_position, status, output ready);
endinterface

@@ design/bdq_front.sv @@
// ---------------------------------------------------------------------------
// bdq_front
// accepts command items and classifies them into queue entries
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_front (
  bdq_cmd_if.sink          cmd_i,
  output logic             enq_valid_o,
  input  logic             enq_ready_i,
  output bdq_pkg::entry_t  enq_entry_o
);
  import bdq_pkg::*;

  op_e op;

  always_comb begin
    unique case (cmd_i.cmd)
      CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  op = OP_PUSH_BACK;
      CMD_POP_BACK:   op = OP_POP_BACK;
      CMD_READ:       op = OP_READ;
      CMD_FIND:       op = OP_FIND;
      default:        op = OP_BAD;
    endcase
  end

  assign enq_valid_o          = cmd_i.valid;
  assign cmd_i.ready          = enq_ready_i;
  assign enq_entry_o.op       = op;
  assign enq_entry_o.value    = cmd_i.data_value;
  assign enq_entry_o.position = cmd_i.position;

endmodule

@@ design/bdq_queue.sv @@
// ---------------------------------------------------------------------------
// bdq_queue
// short fifo of classified commands between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  bdq_pkg::entry_t  push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output bdq_pkg::entry_t  pop_entry_o
);
  import bdq_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  entry_t           store_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]   fill_q;
  logic             do_push, do_pop;

  assign push_ready_o = (fill_q != QCW'(QDEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_entry_o  = store_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + QCW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ design/bdq_back.sv @@
// ---------------------------------------------------------------------------
// bdq_back
// executes queued commands on the slot ring and registers each result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_back #(
  parameter int CAPACITY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             deq_valid_i,
  output logic             deq_ready_o,
  input  bdq_pkg::entry_t  deq_entry_i,
  bdq_res_if.source        res_o
);
  import bdq_pkg::*;

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = $clog2(2 * CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  function automatic logic [PW-1:0] ring(input logic [PW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] wr_data_of(input entry_t e);
    return e.value;
  endfunction

  logic [VALUE_W-1:0]        mem [CAPACITY];

  logic [1:0]                state_q, state_d;
  logic [PW-1:0]             front_q, front_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      init_q, init_d;
  logic [CW-1:0]             issue_q, issue_d;
  logic signed [VALUE_W-1:0] key_q, key_d;
  logic                      rd_valid_q, rd_valid_d;
  logic [VALUE_W-1:0]        rd_q;
  logic                      rd_zero_q;
  logic [CW-1:0]             cmp_idx_q;
  logic                      res_valid_q;
  result_t                   res_q, res_d;

  logic                      wr_en, rd_en, hold_rd, res_set, out_free;
  logic [PW-1:0]             wr_addr, rd_addr;
  logic [CW-1:0]             rd_lidx;
  logic signed [VALUE_W-1:0] rd_value;
  logic [CMPW-1:0]           pos_ext, count_ext, idx_ext;
  logic                      is_full, is_empty;

  assign out_free  = !res_valid_q || res_o.ready;
  assign rd_value  = rd_zero_q ? '0 : rd_q;
  assign pos_ext   = CMPW'(deq_entry_i.position);
  assign count_ext = CMPW'(count_q);
  assign idx_ext   = CMPW'(cmp_idx_q);
  assign is_full   = (count_q == CW'(CAPACITY));
  assign is_empty  = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    issue_d     = issue_q;
    key_d       = key_q;
    wr_en       = 1'b0;
    wr_addr     = front_q;
    rd_en       = 1'b0;
    rd_addr     = front_q;
    rd_lidx     = '0;
    hold_rd     = 1'b0;
    res_set     = 1'b0;
    res_d       = '{result_value: '0, result_position: '0, status: STAT_OK};
    deq_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        deq_ready_o = out_free;
        if (deq_valid_i && out_free) begin
          unique case (deq_entry_i.op)
            OP_PUSH_FRONT: begin
              res_set = 1'b1;
              if (is_full) begin
                res_d.status = STAT_FULL;
              end else begin
                front_d = (front_q == '0) ? PW'(CAPACITY - 1) : front_q - PW'(1);
                wr_en   = 1'b1;
                wr_addr = front_d;
                count_d = count_q + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              res_set = 1'b1;
              if (is_full) begin
                res_d.status = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring(front_q, count_q);
                count_d = count_q + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_set      = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                rd_en   = 1'b1;
                rd_addr = ring(front_q, count_q - CW'(1));
                state_d = S_WAIT;
              end
            end
            OP_READ: begin
              if (is_empty) begin
                res_set      = 1'b1;
                res_d.status = STAT_EMPTY;
              end else if (pos_ext >= count_ext) begin
                res_set      = 1'b1;
                res_d.status = STAT_MISS;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ring(front_q, pos_ext[CW-1:0]);
                state_d = S_WAIT;
              end
            end
            OP_FIND: begin
              if (is_empty) begin
                res_set      = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = front_q;
                rd_lidx = '0;
                issue_d = CW'(1);
                key_d   = deq_entry_i.value;
                state_d = S_FIND;
              end
            end
            default: begin
              res_set      = 1'b1;
              res_d.status = STAT_MISS;
            end
          endcase
        end
      end
      S_WAIT: begin
        if (out_free) begin
          res_set            = 1'b1;
          res_d.result_value = rd_value;
          state_d            = S_IDLE;
        end
      end
      S_FIND: begin
        if (!out_free) begin
          hold_rd = 1'b1;
        end else if (rd_valid_q && (rd_value == key_q)) begin
          res_set               = 1'b1;
          res_d.result_position = idx_ext[POS_W-1:0];
          state_d               = S_IDLE;
        end else if (rd_valid_q && (cmp_idx_q == count_q - CW'(1))) begin
          res_set      = 1'b1;
          res_d.status = STAT_MISS;
          state_d      = S_IDLE;
        end else if (issue_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = ring(front_q, issue_q);
          rd_lidx = issue_q;
          issue_d = issue_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign init_d     = init_q && !(wr_en && (wr_addr == '0));
  assign rd_valid_d = rd_en || (hold_rd && rd_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= CW'(1);
      init_q      <= 1'b1;
      issue_q     <= '0;
      rd_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      front_q    <= front_d;
      count_q    <= count_d;
      init_q     <= init_d;
      issue_q    <= issue_d;
      rd_valid_q <= rd_valid_d;
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // slot ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data_of(deq_entry_i);
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_zero_q <= init_q && (rd_addr == '0);
      cmp_idx_q <= rd_lidx;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (res_set) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.result_value    = res_q.result_value;
  assign res_o.result_position = res_q.result_position;
  assign res_o.status          = res_q.status;

endmodule

@@ design/bounded_deque_with_search.sv @@
// ---------------------------------------------------------------------------
// bounded_deque_with_search
// Ordered list of signed 32-bit values held in a ring of CAPACITY slots,
// with push front, push back, pop back, read at position and find value.
// After reset the list holds one element of value 0. Every command item
// gives exactly one result item with a status (ok, empty, full, miss).
// Commands are decoded by the front and wait in a two-entry queue; the
// back executes one command at a time on a single-port slot memory with a
// registered read. Push commands and commands that fail their check finish
// in the idle state, pop and read go on to the wait state, and find reads
// one slot per cycle while the output register is free, at most CAPACITY slots. A
// result sits in an output register; while it waits to be taken the back
// stalls and the front accepts until the two-entry queue is full.
// No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_deque_with_search #(
  parameter int CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdq_cmd_if.sink    cmd_i,
  bdq_res_if.source  res_o
);
  import bdq_pkg::*;

  logic   enq_valid, enq_ready;
  entry_t enq_entry;
  logic   deq_valid, deq_ready;
  entry_t deq_entry;

  bdq_front u_front (
    .cmd_i       (cmd_i),
    .enq_valid_o (enq_valid),
    .enq_ready_i (enq_ready),
    .enq_entry_o (enq_entry)
  );

  bdq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (enq_valid),
    .push_ready_o (enq_ready),
    .push_entry_i (enq_entry),
    .pop_valid_o  (deq_valid),
    .pop_ready_i  (deq_ready),
    .pop_entry_o  (deq_entry)
  );

  bdq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .deq_valid_i (deq_valid),
    .deq_ready_o (deq_ready),
    .deq_entry_i (deq_entry),
    .res_o       (res_o)
  );

endmodule

@@ design/bdq_checker.sv @@
// ---------------------------------------------------------------------------
// bdq_checker
// port-level checks of the deque: result channel and items in flight
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [bdq_pkg::VALUE_W-1:0] result_value_i,
  input logic [bdq_pkg::POS_W-1:0]          result_position_i,
  input logic [bdq_pkg::STATUS_W-1:0]       status_i
);
  import bdq_pkg::*;

  // queue entries, one item in the back, one in the output register
  localparam int MAX_OPEN = QDEPTH + 2;
  localparam int OW       = $clog2(MAX_OPEN + 2);

  logic [OW-1:0] open_q;
  logic          in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_acc) begin
      open_q <= open_q + OW'(1);
    end else if (out_acc && !in_acc) begin
      open_q <= open_q - OW'(1);
    end
  end

  `ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_out_payload_held, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(result_value_i) && $stable(result_position_i) && $stable(status_i))
  `ASSERT_IMPLY(a_fail_zero_fields, clk_i, rst_ni, out_valid_i && (status_i != STAT_OK), (result_value_i == '0) && (result_position_i == '0))
  `ASSERT_IMPLY(a_result_has_item, clk_i, rst_ni, out_valid_i, open_q != '0)
  `ASSERT_IMPLY(a_open_bounded, clk_i, rst_ni, 1'b1, open_q <= OW'(MAX_OPEN))

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (cmd_i.valid),
  .in_ready_i        (cmd_i.ready),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .result_value_i    (res_o.result_value),
  .result_position_i (res_o.result_position),
  .status_i          (res_o.status)
);
